[src/majority_rule_group_update_unit_assert.svh]
// Assertion macros for the majority-rule group update unit.
// Used by modules that sample on clk and reset on arst_n.
`ifndef MAJORITY_RULE_GROUP_UPDATE_UNIT_ASSERT_SVH
`define MAJORITY_RULE_GROUP_UPDATE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MRGU_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define MRGU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/mrgu_pkg.sv]
// Types and constants of the majority-rule group update unit.
// No dependencies.
package mrgu_pkg;

	localparam int AGENT_W = 10;
	localparam int COUNT_W = 11;
	localparam int SIZE_W  = 5;

	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_MEMBER = 1'b1;

	localparam logic [SIZE_W-1:0] GROUP_SIZE_RESET = 5'd3;

	typedef struct packed {
		logic               action;
		logic [AGENT_W-1:0] agent;
		logic               opinion;
	} item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count_a;
		logic [COUNT_W-1:0] count_b;
		logic               majority;
		logic               consensus;
		logic               tie_error;
	} result_t;

endpackage

[src/mrgu_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mrgu_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[src/majority_rule_group_update_unit.sv]
// Majority-rule group update unit: top level with its sequencer.
// Depends on mrgu_pkg, mrgu_ram and majority_rule_group_update_unit_assert.svh.
//
//   channel  | direction | handshake                  | word
//   ---------+-----------+----------------------------+-----------------------------
//   item     | in        | start & !busy              | action, agent, opinion
//   result   | out       | done (one-cycle strobe)    | count_a, count_b, majority,
//            |           |                            | consensus, tie_error
//   cfg      | in        | cfg_valid & cfg_ready      | group_size (5 bits)
//
// After reset, sweep the opinion memory to B with busy high; cfg writes are taken.
// A load reads the stored opinion, then rewrites it if it changed. A member is
// compared against each one already collected; a duplicate stops early, else
// it is appended. Closing a group of n sums and then decides; a tie posts there,
// otherwise each member is written back and then the word is posted.
// done is high for exactly one cycle; the receiver cannot stall it.
module majority_rule_group_update_unit #(
	parameter int NODE_COUNT = 1024,
	parameter int MAX_GROUP  = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  mrgu_pkg::item_t                    item,
	output logic                               done,
	output mrgu_pkg::result_t                  result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [mrgu_pkg::SIZE_W-1:0]        cfg_data
);

	import mrgu_pkg::*;

	`include "majority_rule_group_update_unit_assert.svh"

	// Widths: store address, group address, member count, agent count.
	localparam int SA    = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int GA    = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
	localparam int NW    = $clog2(MAX_GROUP + 1);
	localparam int CW    = $clog2(NODE_COUNT + 1);
	localparam int EXT_W = (SA > AGENT_W) ? SA : AGENT_W;
	localparam int XW    = (CW > COUNT_W) ? CW : COUNT_W;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_LD_RD,
		S_LD_WR,
		S_DUP_RD,
		S_DUP_CMP,
		S_APPEND,
		S_SUM_GM,
		S_SUM_ST,
		S_SUM_ACC,
		S_DECIDE,
		S_WB_GM,
		S_WB_ST,
		S_WB_CHK,
		S_FINISH
	} state_t;

	state_t               state_q;
	item_t                item_q;
	logic [SIZE_W-1:0]    gs_q;       // group_size register
	logic [NW-1:0]        cnt_q;      // members collected so far
	logic [NW-1:0]        idx_q;      // shared walk index
	logic [NW-1:0]        n_q;        // size of the group being resolved
	logic [NW-1:0]        na_q;       // members holding A
	logic                 maj_q;
	logic [SA-1:0]        clr_q;
	logic [CW-1:0]        ca_q;
	logic [CW-1:0]        cb_q;
	logic                 done_q;
	result_t              result_q;

	logic [NW-1:0]        eff_n;
	logic [NW-1:0]        idx_nxt;
	logic [NW-1:0]        cnt_nxt;
	logic                 agent_ok;
	logic                 tie;
	logic                 maj;
	logic                 cfg_wr;

	// Memory ports.
	logic                 st_we;
	logic [SA-1:0]        st_waddr;
	logic                 st_wdata;
	logic [SA-1:0]        st_raddr;
	logic                 st_rdata;
	logic                 gm_we;
	logic [AGENT_W-1:0]   gm_rdata;

	logic [EXT_W-1:0]     in_ext;
	logic [EXT_W-1:0]     item_ext;
	logic [EXT_W-1:0]     gm_ext;
	logic [XW-1:0]        ca_x;
	logic [XW-1:0]        cb_x;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;
	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign result    = result_q;

	assign in_ext   = EXT_W'(item.agent);
	assign item_ext = EXT_W'(item_q.agent);
	assign gm_ext   = EXT_W'(gm_rdata);
	assign agent_ok = (32'(in_ext) < 32'(NODE_COUNT));

	assign idx_nxt = idx_q + NW'(1);
	assign cnt_nxt = cnt_q + NW'(1);

	// Clamp the configured size into 1..MAX_GROUP.
	always_comb begin
		if (gs_q == '0) begin
			eff_n = NW'(1);
		end else if (int'(gs_q) > MAX_GROUP) begin
			eff_n = NW'(MAX_GROUP);
		end else begin
			eff_n = NW'(gs_q);
		end
	end

	// Compare 2*na against n: equal is a tie, above is majority A.
	assign tie = ({na_q, 1'b0} == {1'b0, n_q});
	assign maj = ({na_q, 1'b0} >  {1'b0, n_q});

	assign ca_x = XW'(ca_q);
	assign cb_x = XW'(cb_q);

	// Opinion memory port steering: sweep, load write, or write-back.
	always_comb begin
		st_we    = 1'b0;
		st_waddr = clr_q;
		st_wdata = 1'b0;
		st_raddr = gm_ext[SA-1:0];
		case (state_q)
			S_CLEAR: begin
				st_we = 1'b1;
			end
			S_LD_RD: begin
				st_raddr = item_ext[SA-1:0];
			end
			S_LD_WR: begin
				st_we    = (st_rdata != item_q.opinion);
				st_waddr = item_ext[SA-1:0];
				st_wdata = item_q.opinion;
			end
			S_WB_CHK: begin
				st_we    = (st_rdata != maj_q);
				st_waddr = gm_ext[SA-1:0];
				st_wdata = maj_q;
			end
			default: begin
				st_we = 1'b0;
			end
		endcase
	end

	assign gm_we = (state_q == S_APPEND);

	mrgu_ram #(
		.WIDTH (1),
		.DEPTH (NODE_COUNT)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	// Member list: written at the fill count, read at the walk index.
	mrgu_ram #(
		.WIDTH (AGENT_W),
		.DEPTH (MAX_GROUP)
	) u_members (
		.clk   (clk),
		.we    (gm_we),
		.waddr (cnt_q[GA-1:0]),
		.wdata (item_q.agent),
		.raddr (idx_q[GA-1:0]),
		.rdata (gm_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			item_q   <= '0;
			gs_q     <= GROUP_SIZE_RESET;
			cnt_q    <= '0;
			idx_q    <= '0;
			n_q      <= '0;
			na_q     <= '0;
			maj_q    <= 1'b0;
			clr_q    <= '0;
			ca_q     <= '0;
			cb_q     <= CW'(NODE_COUNT);
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			// Registered strobe of the word, from a tie in S_DECIDE or from S_FINISH after the final write-back.
			done_q <= (state_q == S_FINISH) || ((state_q == S_DECIDE) && tie);
			if (cfg_wr) begin
				gs_q  <= cfg_data;
				cnt_q <= '0;   // drop any partly gathered group
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + SA'(1);
					if (32'(clr_q) == NODE_COUNT - 1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start && agent_ok) begin
						item_q <= item;
						idx_q  <= '0;
						if (item.action == ACT_LOAD) begin
							state_q <= S_LD_RD;
						end else begin
							state_q <= S_DUP_RD;
						end
					end
				end
				S_LD_RD: begin
					state_q <= S_LD_WR;
				end
				S_LD_WR: begin
					if (st_rdata != item_q.opinion) begin
						if (item_q.opinion) begin
							ca_q <= ca_q + CW'(1);
							cb_q <= cb_q - CW'(1);
						end else begin
							ca_q <= ca_q - CW'(1);
							cb_q <= cb_q + CW'(1);
						end
					end
					state_q <= S_IDLE;
				end
				S_DUP_RD: begin
					if (idx_q == cnt_q) begin
						state_q <= S_APPEND;
					end else begin
						state_q <= S_DUP_CMP;
					end
				end
				S_DUP_CMP: begin
					if (gm_rdata == item_q.agent) begin
						state_q <= S_IDLE;   // already in the group
					end else begin
						idx_q   <= idx_nxt;
						state_q <= S_DUP_RD;
					end
				end
				S_APPEND: begin
					if (cnt_nxt >= eff_n) begin
						cnt_q   <= '0;
						n_q     <= cnt_nxt;
						idx_q   <= '0;
						na_q    <= '0;
						state_q <= S_SUM_GM;
					end else begin
						cnt_q   <= cnt_nxt;
						state_q <= S_IDLE;
					end
				end
				S_SUM_GM: begin
					state_q <= S_SUM_ST;
				end
				S_SUM_ST: begin
					state_q <= S_SUM_ACC;
				end
				S_SUM_ACC: begin
					na_q  <= na_q + NW'(st_rdata);
					idx_q <= idx_nxt;
					if (idx_nxt == n_q) begin
						state_q <= S_DECIDE;
					end else begin
						state_q <= S_SUM_GM;
					end
				end
				S_DECIDE: begin
					idx_q <= '0;
					if (tie) begin
						result_q.count_a   <= ca_x[COUNT_W-1:0];
						result_q.count_b   <= cb_x[COUNT_W-1:0];
						result_q.majority  <= 1'b0;
						result_q.consensus <= (ca_q == '0) || (cb_q == '0);
						result_q.tie_error <= 1'b1;
						state_q            <= S_IDLE;
					end else begin
						maj_q   <= maj;
						state_q <= S_WB_GM;
					end
				end
				S_WB_GM: begin
					state_q <= S_WB_ST;
				end
				S_WB_ST: begin
					state_q <= S_WB_CHK;
				end
				S_WB_CHK: begin
					if (st_rdata != maj_q) begin
						if (maj_q) begin
							ca_q <= ca_q + CW'(1);
							cb_q <= cb_q - CW'(1);
						end else begin
							ca_q <= ca_q - CW'(1);
							cb_q <= cb_q + CW'(1);
						end
					end
					idx_q <= idx_nxt;
					if (idx_nxt == n_q) begin
						state_q <= S_FINISH;
					end else begin
						state_q <= S_WB_GM;
					end
				end
				S_FINISH: begin
					result_q.count_a   <= ca_x[COUNT_W-1:0];
					result_q.count_b   <= cb_x[COUNT_W-1:0];
					result_q.majority  <= maj_q;
					result_q.consensus <= (ca_q == '0) || (cb_q == '0);
					result_q.tie_error <= 1'b0;
					state_q            <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Checks on the sequencer and the running counts.
	`MRGU_ASSERT_SAME(a_count_total, 1'b1, (int'(ca_q) + int'(cb_q)) == NODE_COUNT, "A+B count off")
	`MRGU_ASSERT_SAME(a_fill_bound, 1'b1, int'(cnt_q) < MAX_GROUP, "member fill count too high")
	`MRGU_ASSERT_NEXT(a_done_pulse, done_q, !done_q, "result strobe held too long")
	`MRGU_ASSERT_NEXT(a_busy_after_start, start && !busy && agent_ok, busy, "busy not raised")

endmodule

[sim/tb_majority_rule_group_update_unit.sv]
`timescale 1ns / 100ps
// Self-checking testbench for majority_rule_group_update_unit.
// Depends on mrgu_pkg and the unit's RTL; a class tracks opinions and tallies.

localparam int AGENTS    = 1024;
localparam int GROUP_MAX = 16;

// Mirror of the opinion store, the open group and the A/B head counts.
// Each completed group yields one expected tally word.
class opinion_tally_model;
	bit                               opinion_of[AGENTS];
	logic [mrgu_pkg::AGENT_W-1:0]     group[GROUP_MAX];
	int unsigned                      gathered;
	int unsigned                      holders_a;
	int unsigned                      holders_b;
	logic [mrgu_pkg::SIZE_W-1:0]      size_reg;
	mrgu_pkg::result_t                awaited[$];
	int unsigned                      errors;
	int unsigned                      words_in;
	int unsigned                      checked;
	int unsigned                      ties;
	int unsigned                      unanimous;

	function new();
		holders_b = AGENTS;
		size_reg  = mrgu_pkg::GROUP_SIZE_RESET;
	endfunction

	// A register write also drops the partly gathered group.
	function void set_group_size(logic [mrgu_pkg::SIZE_W-1:0] v);
		size_reg = v;
		gathered = 0;
	endfunction

	function void flip(int unsigned who, bit to_a);
		opinion_of[who] = to_a;
		if (to_a) begin
			holders_a++;
			holders_b--;
		end else begin
			holders_a--;
			holders_b++;
		end
	endfunction

	function void push_tally(bit maj, bit tie);
		mrgu_pkg::result_t r;
		r.count_a   = holders_a[mrgu_pkg::COUNT_W-1:0];
		r.count_b   = holders_b[mrgu_pkg::COUNT_W-1:0];
		r.majority  = maj;
		r.consensus = (holders_a == 0 || holders_b == 0);
		r.tie_error = tie;
		awaited = {awaited, r};
	endfunction

	function void apply_word(mrgu_pkg::item_t w);
		int unsigned limit;
		int unsigned n;
		int unsigned votes;
		bit          maj;
		words_in++;
		if (w.agent >= AGENTS)
			return;
		if (w.action == mrgu_pkg::ACT_LOAD) begin
			if (opinion_of[w.agent] != w.opinion)
				flip(w.agent, w.opinion);
			return;
		end
		for (int i = 0; i < gathered; i++)
			if (group[i] == w.agent)
				return;
		if (gathered < GROUP_MAX) begin
			group[gathered] = w.agent;
			gathered++;
		end
		limit = (size_reg == 0) ? 1 : (size_reg > GROUP_MAX) ? GROUP_MAX : size_reg;
		if (gathered < limit)
			return;
		n        = gathered;
		gathered = 0;
		votes    = 0;
		for (int i = 0; i < n; i++)
			votes += opinion_of[group[i]];
		if (2 * votes == n) begin
			push_tally(1'b0, 1'b1);
			return;
		end
		maj = (2 * votes > n);
		for (int i = 0; i < n; i++)
			if (opinion_of[group[i]] != maj)
				flip(group[i], maj);
		push_tally(maj, 1'b0);
	endfunction

	function void compare_tally(mrgu_pkg::result_t got);
		mrgu_pkg::result_t want;
		if (awaited.size() == 0) begin
			$error("unexpected result word: %p", got);
			errors++;
			return;
		end
		want = awaited.pop_front();
		checked++;
		if (want.tie_error)
			ties++;
		if (want.consensus)
			unanimous++;
		if (got.count_a !== want.count_a) begin
			$error("count_a: expected %0d, got %0d", want.count_a, got.count_a);
			errors++;
		end
		if (got.count_b !== want.count_b) begin
			$error("count_b: expected %0d, got %0d", want.count_b, got.count_b);
			errors++;
		end
		if (got.majority !== want.majority) begin
			$error("majority: expected %0d, got %0d", want.majority, got.majority);
			errors++;
		end
		if (got.consensus !== want.consensus) begin
			$error("consensus: expected %0d, got %0d", want.consensus, got.consensus);
			errors++;
		end
		if (got.tie_error !== want.tie_error) begin
			$error("tie_error: expected %0d, got %0d", want.tie_error, got.tie_error);
			errors++;
		end
	endfunction
endclass

module tb_majority_rule_group_update_unit;
	import mrgu_pkg::*;

	// Longest quiet stretch: the clearing sweep after reset or a full group of 16,
	// with margin.
	localparam int STALL_LIMIT = 5000;
	// Cycles a word that yields no result may still keep the unit busy.
	localparam int QUIET_WAIT  = 40;
	// Drain time at the end: a complete group of GROUP_MAX plus margin.
	localparam int TAIL_WAIT   = 200;
	localparam int PHASES      = 10;
	localparam int PHASE_WORDS = 25;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              start     = 1'b0;
	logic              busy;
	item_t             item      = '0;
	logic              done;
	result_t           result;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [SIZE_W-1:0] cfg_data  = '0;

	opinion_tally_model tally = new();

	// Back-to-back words when set, otherwise a random gap of idle cycles before each word.
	bit fast = 1'b0;
	int unsigned idle_cycles = 0;

	// Include the extremes: 0 acts as 1, 31 saturates at GROUP_MAX.
	logic [SIZE_W-1:0] phase_sizes[8] = '{5'd1, 5'd0, 5'd31, 5'd16, 5'd5, 5'd4, 5'd2, 5'd3};

	majority_rule_group_update_unit #(
		.NODE_COUNT(AGENTS),
		.MAX_GROUP (GROUP_MAX)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.done     (done),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Sample the result strobe on the edge that ends its cycle.
	always @(posedge clk) begin
		if (arst_n && done)
			tally.compare_tally(result);
	end

	// Count cycles in which no word moves on any channel; give up past the limit.
	always @(posedge clk) begin
		if ((start && !busy) || (cfg_valid && cfg_ready) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Present one word, hold it until the unit takes it, then note it.
	// Leave start high on return so a back-to-back word needs no toggle.
	task automatic send(input logic act, input logic [AGENT_W-1:0] ag, input logic op);
		item_t w;
		int    gap;
		w   = '{action: act, agent: ag, opinion: op};
		gap = fast ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item  <= w;
		do
			@(posedge clk);
		while (busy);
		tally.apply_word(w);
	endtask

	// Drop start and hold off until every expected tally has arrived.
	task automatic drain();
		start <= 1'b0;
		do
			@(posedge clk);
		while (tally.awaited.size() != 0);
	endtask

	// Write group_size only once the unit has gone quiet.
	task automatic write_group_size(input logic [SIZE_W-1:0] sz);
		drain();
		repeat (QUIET_WAIT) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= sz;
		do
			@(posedge clk);
		while (!cfg_ready);
		tally.set_group_size(sz);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [SIZE_W-1:0]  sz;
		logic [AGENT_W-1:0] hot_base;
		logic [AGENT_W-1:0] ag;
		logic               act;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset group size of 3, loads that change and loads that do not.
		send(ACT_LOAD, 10'd0, 1'b1);
		send(ACT_LOAD, 10'd1023, 1'b1);
		send(ACT_LOAD, 10'd1023, 1'b1);
		send(ACT_LOAD, 10'd5, 1'b0);
		// Group with a duplicate member; A wins two to one.
		send(ACT_MEMBER, 10'd0, 1'b0);
		send(ACT_MEMBER, 10'd0, 1'b1);
		send(ACT_MEMBER, 10'd1023, 1'b0);
		send(ACT_MEMBER, 10'd7, 1'b1);
		// Reload a member already in the open group; B wins.
		send(ACT_MEMBER, 10'd7, 1'b0);
		send(ACT_LOAD, 10'd7, 1'b0);
		send(ACT_MEMBER, 10'd8, 1'b1);
		send(ACT_MEMBER, 10'd9, 1'b0);
		// Clear every A and close a group: all agents on B.
		send(ACT_LOAD, 10'd0, 1'b0);
		send(ACT_LOAD, 10'd1023, 1'b0);
		send(ACT_MEMBER, 10'd100, 1'b1);
		send(ACT_MEMBER, 10'd200, 1'b0);
		send(ACT_MEMBER, 10'd300, 1'b1);

		// Pairs give ties; an open member is dropped by the next write.
		write_group_size(5'd2);
		send(ACT_LOAD, 10'd0, 1'b1);
		send(ACT_MEMBER, 10'd0, 1'b0);
		send(ACT_MEMBER, 10'd1, 1'b1);
		send(ACT_MEMBER, 10'd512, 1'b1);

		// Turn every agent to A, then close a pair: count_a at its top.
		write_group_size(5'd2);
		fast = 1'b1;
		for (int i = 0; i < AGENTS; i++)
			send(ACT_LOAD, i[AGENT_W-1:0], 1'b1);
		fast = 1'b0;
		send(ACT_MEMBER, 10'd0, 1'b0);
		send(ACT_MEMBER, 10'd1023, 1'b1);

		// Random phases: mostly members, two in five from a narrow window so groups fill
		// with repeats and mixed opinions; the rest spread over all agents.
		for (int p = 0; p < PHASES; p++) begin
			sz = (p < 8) ? phase_sizes[p] : SIZE_W'($urandom_range(0, 31));
			write_group_size(sz);
			fast     = ($urandom_range(0, 3) == 0);
			hot_base = AGENT_W'($urandom_range(0, AGENTS - 16));
			repeat (PHASE_WORDS) begin
				if ($urandom_range(0, 79) == 0)
					drain();
				act = ($urandom_range(0, 3) == 0) ? ACT_LOAD : ACT_MEMBER;
				if ($urandom_range(0, 4) < 2)
					ag = hot_base + AGENT_W'($urandom_range(0, 15));
				else
					ag = AGENT_W'($urandom_range(0, AGENTS - 1));
				send(act, ag, 1'($urandom_range(0, 1)));
			end
		end

		drain();
		repeat (TAIL_WAIT) @(posedge clk);

		$display("tb: %0d words sent over %0d group-size settings (0 through 31)",
			tally.words_in, PHASES + 3);
		$display("tb: %0d tallies checked, %0d ties, %0d with consensus",
			tally.checked, tally.ties, tally.unanimous);
		if (tally.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[sim.f]
+incdir+src
src/mrgu_pkg.sv
src/mrgu_ram.sv
src/majority_rule_group_update_unit.sv
sim/tb_majority_rule_group_update_unit.sv
